// File: hw/rtl/block_delta_encoder_unit_assert.svh
// assertion macros for the block delta encoder checker
// no dependencies; included by the checker module
`ifndef BLOCK_DELTA_ENCODER_UNIT_ASSERT_SVH
`define BLOCK_DELTA_ENCODER_UNIT_ASSERT_SVH

// property must hold at every edge out of reset
`define BDE_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("block delta encoder check failed");

// property must never hold at any edge out of reset
`define BDE_ASSERT_NEVER(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) not (prop)) \
    else $error("block delta encoder forbidden condition seen");

`endif

// File: hw/rtl/bde_pkg.sv
// shared constants, types and state encoding of the block delta encoder
// no dependencies; imported by bde_queue, bde_front, bde_back and the top level
`default_nettype none

package bde_pkg;

  localparam int unsigned WORDS_PER_BLOCK = 32;
  localparam int unsigned IDX_W = (WORDS_PER_BLOCK > 1) ? $clog2(WORDS_PER_BLOCK) : 1;
  localparam int unsigned CNT_W = $clog2(WORDS_PER_BLOCK + 1);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [3:0] FULL_BYTES = 4'd8;
  localparam logic [3:0] FLAG_BYTES = 4'd1;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        differs;
    logic        last;
  } entry_t;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_FLAG,
    ST_READ,
    ST_EMIT
  } back_state_e;

endpackage

`default_nettype wire

// File: hw/rtl/bde_queue.sv
// short item queue between the front and back parts
// depends on bde_pkg for the entry type and depth
`default_nettype none

module bde_queue
  import bde_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire entry_t push_entry_i,
  output logic        full_o,
  input  wire logic   pop_i,
  output entry_t      pop_entry_o,
  output logic        valid_o
);

  entry_t              slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o      = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o     = (cnt_q != '0);
  assign pop_entry_o = slots_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bde_front.sv
// front part: accepts input items, trims the byte count, masks and compares
// depends on bde_pkg; feeds bde_queue
`default_nettype none

module bde_front
  import bde_pkg::*;
(
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] state_word_i,
  input  wire logic [3:0]  valid_bytes_i,
  input  wire logic [63:0] base_word_i,
  input  wire logic        base_covers_i,
  input  wire logic        final_word_i,
  input  wire logic        q_full_i,
  output logic             push_o,
  output entry_t           push_entry_o
);

  logic [3:0]  nbytes;
  logic [63:0] mask;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    if (!final_word_i) begin
      nbytes = FULL_BYTES;
    end else if (valid_bytes_i == 4'd0) begin
      nbytes = FLAG_BYTES;
    end else if (valid_bytes_i > FULL_BYTES) begin
      nbytes = FULL_BYTES;
    end else begin
      nbytes = valid_bytes_i;
    end
  end

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      mask[b*8 +: 8] = (4'(b) < nbytes) ? 8'hff : 8'h00;
    end
  end

  always_comb begin
    push_entry_o.word    = state_word_i & mask;
    push_entry_o.nbytes  = nbytes;
    push_entry_o.differs = !base_covers_i || (((state_word_i ^ base_word_i) & mask) != '0);
    push_entry_o.last    = final_word_i;
  end

endmodule

`default_nettype wire

// File: hw/rtl/bde_back.sv
// back part: block store, block bookkeeping and result sequencing
// depends on bde_pkg; drains bde_queue and drives the output register
`default_nettype none

module bde_back
  import bde_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   q_valid_i,
  input  wire entry_t q_entry_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  wire logic   out_stall_i,
  output logic        is_flag_o,
  output logic [63:0] payload_o,
  output logic [3:0]  byte_count_o,
  output logic        run_last_o,
  output logic        stream_last_o
);

  back_state_e        state_q, state_d;
  logic [63:0]        block_store_q [WORDS_PER_BLOCK];
  logic [63:0]        rd_data_q;
  logic [CNT_W-1:0]   wc_q, wc_d;
  logic [IDX_W-1:0]   rd_idx_q, rd_idx_d;
  logic               diff_q, diff_d;
  logic [3:0]         tail_q, tail_d;
  logic               fin_q, fin_d;

  logic               out_valid_q, out_valid_d;
  logic               is_flag_q, is_flag_d;
  logic [63:0]        payload_q, payload_d;
  logic [3:0]         byte_count_q, byte_count_d;
  logic               run_last_q, run_last_d;
  logic               stream_last_q, stream_last_d;

  logic               out_free, pop, closes, last_lit, mem_we, mem_re, load;

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop      = (state_q == ST_COLLECT) && q_valid_i;
  assign closes   = q_entry_i.last || (wc_q == CNT_W'(WORDS_PER_BLOCK - 1));
  assign last_lit = (CNT_W'(rd_idx_q) + CNT_W'(1)) == wc_q;
  assign mem_we   = pop;
  assign mem_re   = (state_q == ST_READ);
  assign q_pop_o  = pop;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_COLLECT: begin
        if (pop && closes) begin
          state_d = ST_FLAG;
        end
      end
      ST_FLAG: begin
        if (out_free) begin
          state_d = diff_q ? ST_READ : ST_COLLECT;
        end
      end
      ST_READ: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = last_lit ? ST_COLLECT : ST_READ;
        end
      end
      default: begin
        state_d = ST_COLLECT;
      end
    endcase
  end

  // bookkeeping and output register loads
  always_comb begin
    wc_d          = wc_q;
    rd_idx_d      = rd_idx_q;
    diff_d        = diff_q;
    tail_d        = tail_q;
    fin_d         = fin_q;
    load          = 1'b0;
    is_flag_d     = is_flag_q;
    payload_d     = payload_q;
    byte_count_d  = byte_count_q;
    run_last_d    = run_last_q;
    stream_last_d = stream_last_q;
    unique case (state_q)
      ST_COLLECT: begin
        if (pop) begin
          wc_d   = wc_q + CNT_W'(1);
          diff_d = diff_q | q_entry_i.differs;
          tail_d = q_entry_i.nbytes;
          fin_d  = q_entry_i.last;
        end
      end
      ST_FLAG: begin
        if (out_free) begin
          load          = 1'b1;
          is_flag_d     = 1'b1;
          payload_d     = {63'd0, diff_q};
          byte_count_d  = FLAG_BYTES;
          run_last_d    = !diff_q;
          stream_last_d = !diff_q && fin_q;
          rd_idx_d      = '0;
          if (!diff_q) begin
            wc_d   = '0;
            diff_d = 1'b0;
            tail_d = FULL_BYTES;
            fin_d  = 1'b0;
          end
        end
      end
      ST_READ: begin
      end
      ST_EMIT: begin
        if (out_free) begin
          load          = 1'b1;
          is_flag_d     = 1'b0;
          payload_d     = rd_data_q;
          byte_count_d  = last_lit ? tail_q : FULL_BYTES;
          run_last_d    = last_lit;
          stream_last_d = last_lit && fin_q;
          if (last_lit) begin
            wc_d   = '0;
            diff_d = 1'b0;
            tail_d = FULL_BYTES;
            fin_d  = 1'b0;
          end else begin
            rd_idx_d = rd_idx_q + IDX_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
    out_valid_d = load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_COLLECT;
      wc_q        <= '0;
      rd_idx_q    <= '0;
      diff_q      <= 1'b0;
      tail_q      <= FULL_BYTES;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wc_q        <= wc_d;
      rd_idx_q    <= rd_idx_d;
      diff_q      <= diff_d;
      tail_q      <= tail_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_flag_q     <= is_flag_d;
    payload_q     <= payload_d;
    byte_count_q  <= byte_count_d;
    run_last_q    <= run_last_d;
    stream_last_q <= stream_last_d;
  end

  // block store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      block_store_q[wc_q[IDX_W-1:0]] <= q_entry_i.word;
    end
    if (mem_re) begin
      rd_data_q <= block_store_q[rd_idx_q];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign is_flag_o     = is_flag_q;
  assign payload_o     = payload_q;
  assign byte_count_o  = byte_count_q;
  assign run_last_o    = run_last_q;
  assign stream_last_o = stream_last_q;

endmodule

`default_nettype wire

// File: hw/rtl/block_delta_encoder_unit.sv
// Block delta encoder. Snapshot words are compared with the reference word at the same
// offset and gathered into blocks of 32 words; a block closes when full or on the final
// word. A block that fully matched a covering reference gives one flag item of value 0;
// any other gives a flag item of value 1 followed by its words as literals, bytes above
// the valid count zeroed. Input words enter one per cycle, unless the queue is full, into a
// two-entry queue while the back part collects them into the block store. Once a block
// closes, the back part stops taking words until it has sent the flag and, for a differing
// block, each literal, which is read from the block store into a read register before it
// reaches the output register. Results sit in that output register: while the last result
// of a block is stalled the next block's words keep flowing, but a stalled flag or literal
// holds the back part and the input stalls once the queue holds two words.
// top level; depends on bde_pkg, bde_front, bde_queue and bde_back
`default_nettype none

module block_delta_encoder_unit
  import bde_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] state_word_i,
  input  wire logic [3:0]  valid_bytes_i,
  input  wire logic [63:0] base_word_i,
  input  wire logic        base_covers_i,
  input  wire logic        final_word_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             is_flag_o,
  output logic [63:0]      payload_o,
  output logic [3:0]       byte_count_o,
  output logic             run_last_o,
  output logic             stream_last_o
);

  logic   q_full, q_push, q_pop, q_valid;
  entry_t push_entry, pop_entry;

  bde_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .state_word_i  (state_word_i),
    .valid_bytes_i (valid_bytes_i),
    .base_word_i   (base_word_i),
    .base_covers_i (base_covers_i),
    .final_word_i  (final_word_i),
    .q_full_i      (q_full),
    .push_o        (q_push),
    .push_entry_o  (push_entry)
  );

  bde_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .pop_entry_o  (pop_entry),
    .valid_o      (q_valid)
  );

  bde_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_entry_i     (pop_entry),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .is_flag_o     (is_flag_o),
    .payload_o     (payload_o),
    .byte_count_o  (byte_count_o),
    .run_last_o    (run_last_o),
    .stream_last_o (stream_last_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/bde_checker.sv
// port-level checks on the result channel of the block delta encoder
// depends on block_delta_encoder_unit_assert.svh; bound to the top level
`default_nettype none

`include "block_delta_encoder_unit_assert.svh"

module bde_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        is_flag_o,
  input wire logic [63:0] payload_o,
  input wire logic [3:0]  byte_count_o,
  input wire logic        run_last_o,
  input wire logic        stream_last_o
);

  // a stalled item stays offered
  `BDE_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o)

  // a flag carries one byte of value 0 or 1
  `BDE_ASSERT(a_flag_form, clk_i, rst_ni, out_valid_o && is_flag_o |-> byte_count_o == 4'd1 && payload_o[63:1] == 63'd0)

  // only the last literal of a block may be short
  `BDE_ASSERT(a_lit_full, clk_i, rst_ni, out_valid_o && !is_flag_o && !run_last_o |-> byte_count_o == 4'd8)

  // stream end is always a block end
  `BDE_ASSERT_NEVER(a_stream_run, clk_i, rst_ni, out_valid_o && stream_last_o && !run_last_o)

endmodule

bind block_delta_encoder_unit bde_checker u_bde_checker (.*);

`default_nettype wire

// File: tb/block_delta_encoder_unit_test.sv
// self-checking testbench for the block delta encoder: directed and random snapshot streams
// with random gaps and stalls, each output item checked against an in-line block predictor
// depends on bde_pkg and block_delta_encoder_unit
module block_delta_encoder_unit_test;
  import bde_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] FLAG_SAME    = 64'd0;
  localparam logic [63:0] FLAG_DIFFERS = 64'd1;

  typedef struct packed {
    logic [63:0] state_word;
    logic [3:0]  valid_bytes;
    logic [63:0] base_word;
    logic        covers;
    logic        fin;
  } snap_word_t;

  typedef struct packed {
    logic        is_flag;
    logic [63:0] payload;
    logic [3:0]  byte_count;
    logic        run_last;
    logic        stream_last;
  } enc_item_t;

  typedef enum int {
    SEQ_MATCH,
    SEQ_ONE_BAD,
    SEQ_NOISE
  } seq_kind_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [63:0] state_word_i = '0;
  logic [3:0]  valid_bytes_i = FULL_BYTES;
  logic [63:0] base_word_i = '0;
  logic        base_covers_i = 1'b0;
  logic        final_word_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        is_flag_o;
  logic [63:0] payload_o;
  logic [3:0]  byte_count_o;
  logic        run_last_o;
  logic        stream_last_o;

  block_delta_encoder_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .state_word_i  (state_word_i),
    .valid_bytes_i (valid_bytes_i),
    .base_word_i   (base_word_i),
    .base_covers_i (base_covers_i),
    .final_word_i  (final_word_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .is_flag_o     (is_flag_o),
    .payload_o     (payload_o),
    .byte_count_o  (byte_count_o),
    .run_last_o    (run_last_o),
    .stream_last_o (stream_last_o)
  );

  always #5 clk_i = ~clk_i;

  snap_word_t snapshot_q[$];
  enc_item_t  encoded_q[$];
  snap_word_t cur_word;
  enc_item_t  want_item;
  int         mismatch_count = 0;
  int         gap_left = 0;
  int         calm_in = 0;
  int         stall_left = 0;
  int         calm_out = 0;

  // predictor state for the block being gathered
  logic [63:0] blk_words [WORDS_PER_BLOCK];
  int          blk_count = 0;
  logic        blk_differs = 1'b0;
  logic [3:0]  blk_tail = FULL_BYTES;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [3:0] eff_bytes(logic [3:0] vb, logic fin);
    if (!fin) return FULL_BYTES;
    if (vb == 4'd0) return 4'd1;
    if (vb > FULL_BYTES) return FULL_BYTES;
    return vb;
  endfunction

  function automatic logic [63:0] low_bytes(logic [3:0] n);
    if (n >= FULL_BYTES) return '1;
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic queue_word(snap_word_t w);
    snapshot_q = {snapshot_q, w};
  endtask

  task automatic queue_result(enc_item_t e);
    encoded_q = {encoded_q, e};
  endtask

  task automatic add_word(logic [63:0] sw, logic [3:0] vb, logic [63:0] bw, logic cov,
                          logic fin);
    snap_word_t w;
    w = {sw, vb, bw, cov, fin};
    queue_word(w);
  endtask

  task automatic encode_word(snap_word_t w);
    logic [3:0]  nb;
    logic [63:0] m;
    logic        last;
    nb = eff_bytes(w.valid_bytes, w.fin);
    m  = low_bytes(nb);
    if (!w.covers || ((w.state_word ^ w.base_word) & m) != 64'd0) blk_differs = 1'b1;
    blk_words[blk_count] = w.state_word & m;
    blk_count++;
    blk_tail = nb;
    if (blk_count == WORDS_PER_BLOCK || w.fin) begin
      if (!blk_differs) begin
        queue_result({1'b1, FLAG_SAME, FLAG_BYTES, 1'b1, w.fin});
      end else begin
        queue_result({1'b1, FLAG_DIFFERS, FLAG_BYTES, 1'b0, 1'b0});
        for (int i = 0; i < blk_count; i++) begin
          last = (i == blk_count - 1);
          queue_result({1'b0, blk_words[i], last ? blk_tail : FULL_BYTES, last,
                        last && w.fin});
        end
      end
      blk_count   = 0;
      blk_differs = 1'b0;
      blk_tail    = FULL_BYTES;
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s at %0t: got %0h, wanted %0h", what, $realtime, got, want);
    mismatch_count++;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) encode_word(cur_word);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (snapshot_q.size() > 0) begin
          cur_word = snapshot_q.pop_front();
          state_word_i  <= cur_word.state_word;
          valid_bytes_i <= cur_word.valid_bytes;
          base_word_i   <= cur_word.base_word;
          base_covers_i <= cur_word.covers;
          final_word_i  <= cur_word.fin;
          in_valid_i    <= 1'b1;
          if (calm_in > 0) begin
            calm_in--;
            gap_left = 0;
          end else begin
            gap_left = idle_len();
            if ($urandom_range(0, 15) == 0) calm_in = $urandom_range(10, 40);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (encoded_q.size() == 0) begin
          report_mismatch("item with nothing outstanding", payload_o, 64'd0);
        end else begin
          want_item = encoded_q.pop_front();
          if (is_flag_o !== want_item.is_flag)
            report_mismatch("is_flag", 64'(is_flag_o), 64'(want_item.is_flag));
          if (payload_o !== want_item.payload)
            report_mismatch("payload", payload_o, want_item.payload);
          if (byte_count_o !== want_item.byte_count)
            report_mismatch("byte_count", 64'(byte_count_o), 64'(want_item.byte_count));
          if (run_last_o !== want_item.run_last)
            report_mismatch("run_last", 64'(run_last_o), 64'(want_item.run_last));
          if (stream_last_o !== want_item.stream_last)
            report_mismatch("stream_last", 64'(stream_last_o), 64'(want_item.stream_last));
        end
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        if (calm_out > 0) begin
          calm_out--;
        end else if ($urandom_range(0, 3) == 0) begin
          stall_left = idle_len();
          if ($urandom_range(0, 15) == 0) calm_out = $urandom_range(20, 80);
        end
      end
    end
  end

  initial begin : stimulus
    int          len;
    int          bad;
    int          b;
    int          r;
    int          total;
    seq_kind_e   kind;
    snap_word_t  w;
    logic [3:0]  nb;
    logic [63:0] m;
    logic [63:0] x;

    // single matching word, full bytes
    x = rand64();
    add_word(x, 4'd8, x, 1'b1, 1'b1);
    // zero valid bytes on the final word counts as one
    x = rand64();
    add_word(x ^ 64'hFFFF_FFFF_FFFF_FF00, 4'd0, x, 1'b1, 1'b1);
    // valid bytes above eight counts as eight
    x = rand64();
    add_word(x, 4'd15, ~x, 1'b1, 1'b1);
    // reference not covering, bytes equal
    x = rand64();
    add_word(x, 4'd3, x, 1'b0, 1'b1);
    // partial count on a non-final word is ignored
    x = rand64();
    add_word(x, 4'd2, x ^ 64'hFF00_0000_0000_0000, 1'b1, 1'b0);
    x = rand64();
    add_word(x, 4'd8, x, 1'b1, 1'b1);
    // field extremes
    add_word('1, 4'd8, '0, 1'b1, 1'b1);
    add_word('0, 4'd1, '0, 1'b1, 1'b1);
    add_word('1, 4'd7, '1, 1'b1, 1'b1);
    add_word('1, 4'd9, {1'b0, {63{1'b1}}}, 1'b1, 1'b1);
    // matching stream, difference only above the final valid bytes
    x = rand64();
    add_word(x, 4'd0, x, 1'b1, 1'b0);
    x = rand64();
    add_word(x, 4'd15, x, 1'b1, 1'b0);
    x = rand64();
    add_word(x, 4'd5, x ^ 64'hFFFF_FF00_0000_0000, 1'b1, 1'b1);
    // uncovered word in the middle of a stream
    x = rand64();
    add_word(x, 4'd8, x, 1'b1, 1'b0);
    x = rand64();
    add_word(x, 4'd8, x, 1'b0, 1'b0);
    x = rand64();
    add_word(x, 4'd8, x, 1'b1, 1'b1);

    total = snapshot_q.size();
    while (total < 100) begin
      r = $urandom_range(0, 9);
      if (r < 5) begin
        len = $urandom_range(1, 4);
      end else if (r < 8) begin
        len = $urandom_range(5, 20);
      end else begin
        case ($urandom_range(0, 3))
          0: len = WORDS_PER_BLOCK - 1;
          1: len = WORDS_PER_BLOCK;
          2: len = WORDS_PER_BLOCK + 1;
          default: len = 2 * WORDS_PER_BLOCK;
        endcase
      end
      if (len > 100 - total) len = 100 - total;
      r = $urandom_range(0, 9);
      kind = (r < 4) ? SEQ_MATCH : ((r < 7) ? SEQ_ONE_BAD : SEQ_NOISE);
      bad = $urandom_range(0, len - 1);
      for (int k = 0; k < len; k++) begin
        w.fin         = (k == len - 1);
        w.valid_bytes = 4'($urandom_range(0, 15));
        w.base_word   = rand64();
        w.covers      = 1'b1;
        nb = eff_bytes(w.valid_bytes, w.fin);
        m  = low_bytes(nb);
        w.state_word = (w.base_word & m) | (rand64() & ~m);
        if (kind == SEQ_NOISE) begin
          if ($urandom_range(0, 1)) w.state_word = rand64();
          w.covers = 1'($urandom_range(0, 1));
        end else if (kind == SEQ_ONE_BAD && k == bad) begin
          if ($urandom_range(0, 1)) begin
            w.covers = 1'b0;
          end else begin
            b = $urandom_range(0, nb - 1);
            w.state_word = w.state_word ^ (64'hFF << (8 * b));
          end
        end
        queue_word(w);
      end
      total += len;
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (snapshot_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (encoded_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatch_count == 0 && encoded_q.size() == 0) begin
      $display("block_delta_encoder_unit_test passed");
    end else begin
      $display("block_delta_encoder_unit_test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("block_delta_encoder_unit_test failed");
    $finish;
  end

endmodule
